/* src/sws_pkg.sv */
package sws_pkg;

   localparam int SYMBOL_W   = 8;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_BITS   = 3;

   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_SIMPLE,
      ST_PAT_RD,
      ST_PAT_UPD,
      ST_TXT_OLD,
      ST_TXT_UPD_OLD,
      ST_TXT_RD_S,
      ST_TXT_UPD_S,
      ST_PUSH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture accepted item
      logic clear;    // wipe search state
      logic simple;   // item with no memory traffic
      logic pat_upd;  // pattern byte: write balance, bump counts
      logic old_rd;   // read balance of evicted byte
      logic old_upd;  // evicted byte: balance + 1
      logic s_upd;    // new text byte: balance - 1, slide window
      logic push;     // move result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              pat_ok;
      logic              len_zero;
      logic              evict;
      logic              out_free;
   } sts_type;

endpackage

/* src/sliding_window_anagram_search_top.sv */
// Sliding-window anagram search over a byte stream.
// Input channel (req_): one transfer per item. req_tuser carries the mode
// (clear, pattern byte, text byte), req_tdata the byte. Pattern bytes load
// per-symbol counts; text bytes slide a window as long as the pattern and
// report whether the window ending at that byte is a permutation.
// Result channel (rsp_): exactly one transfer per item, in item order, with
// window_match, a sticky match_seen and pattern_full (byte dropped).
// Timing: one item is processed at a time through a sequencer over two
// single-write RAMs (symbol balances and the text window ring). After
// DECODE, clear, unused mode, ignored pattern bytes and text against an
// empty pattern pass through CLEAR or SIMPLE; a loaded pattern byte reads
// and writes its balance; a text byte reads and writes the balance of the
// new byte, after first (once the window is full) reading the evicted byte
// from the ring and doing a read-modify-write of its balance. The next
// item can be accepted in the cycle after the result is loaded.
// Reset: synchronous, clears the pattern, window and sticky-match state (per-symbol
// membership flags gate the balance RAM, so no clearing pass is needed).
// A clear item does the same and answers with all flags zero.
// Stall: the result register holds while rsp_tready is low; one more item
// may be accepted and processed, then waits until the register frees.
module sliding_window_anagram_search_top #(
   parameter int PATTERN_MAX   = 256,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sws_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] symbol
   input  logic [sws_pkg::REQ_USER_W-1:0] req_tuser,   // [1:0] mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sws_pkg::RSP_DATA_W-1:0] rsp_tdata    // [0] window_match, [1] match_seen,
                                                       // [2] pattern_full, [7:3] zero
);

   sws_pkg::cmd_type cmd;
   sws_pkg::sts_type sts;

   // sequencer
   sws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // counters, membership flags, memories and result register
   sws_dp #(
      .PATTERN_MAX   (PATTERN_MAX),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // a window match always sets the sticky flag in the same result
   a_match_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> rsp_tdata[1])
      else $error("window_match without match_seen");

   // a text hit and a dropped pattern byte never share one result
   a_hit_xor_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[2]))
      else $error("window_match and pattern_full both set");

   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("back-to-back accept");

endmodule

/* src/sws_ram.sv */
module sws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/sws_ctrl.sv */
module sws_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sws_pkg::sts_type  sts,
   output sws_pkg::cmd_type  cmd
);

   sws_pkg::state_type state_ff;
   sws_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sws_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = sws_pkg::ST_DECODE;
         end
         sws_pkg::ST_DECODE: begin
            case (sts.mode)
               sws_pkg::MODE_CLEAR: begin
                  state_in = sws_pkg::ST_CLEAR;
               end
               sws_pkg::MODE_PATTERN: begin
                  state_in = sts.pat_ok ? sws_pkg::ST_PAT_RD : sws_pkg::ST_SIMPLE;
               end
               sws_pkg::MODE_TEXT: begin
                  if (sts.len_zero) begin
                     state_in = sws_pkg::ST_SIMPLE;
                  end else if (sts.evict) begin
                     state_in = sws_pkg::ST_TXT_OLD;
                  end else begin
                     state_in = sws_pkg::ST_TXT_RD_S;
                  end
               end
               default: state_in = sws_pkg::ST_SIMPLE;
            endcase
         end
         sws_pkg::ST_CLEAR:       state_in = sws_pkg::ST_PUSH;
         sws_pkg::ST_SIMPLE:      state_in = sws_pkg::ST_PUSH;
         sws_pkg::ST_PAT_RD:      state_in = sws_pkg::ST_PAT_UPD;
         sws_pkg::ST_PAT_UPD:     state_in = sws_pkg::ST_PUSH;
         sws_pkg::ST_TXT_OLD:     state_in = sws_pkg::ST_TXT_UPD_OLD;
         sws_pkg::ST_TXT_UPD_OLD: state_in = sws_pkg::ST_TXT_RD_S;
         sws_pkg::ST_TXT_RD_S:    state_in = sws_pkg::ST_TXT_UPD_S;
         sws_pkg::ST_TXT_UPD_S:   state_in = sws_pkg::ST_PUSH;
         sws_pkg::ST_PUSH: begin
            if (sts.out_free) state_in = sws_pkg::ST_IDLE;
         end
         default: state_in = sws_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sws_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         sws_pkg::ST_CLEAR:       cmd.clear   = 1'b1;
         sws_pkg::ST_SIMPLE:      cmd.simple  = 1'b1;
         sws_pkg::ST_PAT_UPD:     cmd.pat_upd = 1'b1;
         sws_pkg::ST_TXT_OLD:     cmd.old_rd  = 1'b1;
         sws_pkg::ST_TXT_UPD_OLD: cmd.old_upd = 1'b1;
         sws_pkg::ST_TXT_UPD_S:   cmd.s_upd   = 1'b1;
         sws_pkg::ST_PUSH:        cmd.push    = sts.out_free;
         default: ;
      endcase
   end

endmodule

/* src/sws_dp.sv */
module sws_dp #(
   parameter int PATTERN_MAX   = 256,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sws_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [sws_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sws_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  sws_pkg::cmd_type                   cmd,
   output sws_pkg::sts_type                   sts
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int PTR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int SYM_W = $clog2(ALPHABET_SIZE);
   localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);
   localparam int BAL_W = LEN_W + 1;

   // captured item
   logic [sws_pkg::MODE_W-1:0] mode_ff;
   logic [SYM_W-1:0]           sym_ff;
   logic [SYM_W-1:0]           sym_map;
   logic [SYM_W-1:0]           old_ff;

   // search state
   logic [ALPHABET_SIZE-1:0] in_pat_ff, in_pat_in;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         seen_ff, seen_in;
   logic [CNT_W-1:0]         distinct_ff, distinct_in;
   logic [CNT_W-1:0]         matched_ff, matched_in;
   logic                     found_ff, found_in;
   logic                     res_hit_ff, res_hit_in;
   logic                     res_full_ff, res_full_in;

   // output register
   logic                     rsp_valid_ff;
   logic [sws_pkg::RSP_BITS-1:0] rsp_bits_ff;

   // memories
   logic [BAL_W-1:0] bal_rdata, bal_wdata;
   logic [SYM_W-1:0] bal_raddr, bal_waddr;
   logic             bal_we;
   logic [SYM_W-1:0] win_rdata;

   // balance update
   logic [SYM_W-1:0] adj_addr;
   logic             adj_member;
   logic [BAL_W-1:0] bal_eff;
   logic [BAL_W-1:0] bal_new;
   logic [CNT_W-1:0] matched_base;
   logic [CNT_W-1:0] matched_adj;
   logic             text_hit;
   logic             simple_hit;
   logic             simple_full;
   logic             len_below_max;

   // out-of-alphabet symbols saturate to the top symbol
   always_comb begin
      if ({1'b0, req_tdata} >= (sws_pkg::SYMBOL_W + 1)'(ALPHABET_SIZE)) begin
         sym_map = SYM_W'(ALPHABET_SIZE - 1);
      end else begin
         sym_map = req_tdata[SYM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_tuser;
         sym_ff  <= sym_map;
      end
      if (cmd.old_rd) begin
         old_ff <= win_rdata;
      end
   end

   assign len_below_max = (len_ff < LEN_W'(PATTERN_MAX));
   assign simple_hit    = (mode_ff == sws_pkg::MODE_TEXT) && (len_ff == '0);
   assign simple_full   = (mode_ff == sws_pkg::MODE_PATTERN) && (seen_ff == '0)
                          && !len_below_max;

   // shared balance adjust: pattern +1, evicted byte +1, new text byte -1
   assign adj_addr   = cmd.old_upd ? old_ff : sym_ff;
   assign adj_member = in_pat_ff[adj_addr];
   assign bal_eff    = adj_member ? bal_rdata : '0;
   assign bal_new    = cmd.s_upd ? (bal_eff - BAL_W'(1)) : (bal_eff + BAL_W'(1));

   always_comb begin
      matched_base = matched_ff;
      if (cmd.pat_upd && !adj_member) begin
         matched_base = matched_ff + CNT_W'(1);
      end
      if (cmd.pat_upd || adj_member) begin
         matched_adj = matched_base - CNT_W'(bal_eff == '0) + CNT_W'(bal_new == '0);
      end else begin
         matched_adj = matched_ff;
      end
   end

   always_comb begin
      seen_in = seen_ff;
      if (cmd.s_upd && (seen_ff < len_ff)) begin
         seen_in = seen_ff + LEN_W'(1);
      end
   end

   assign text_hit = (seen_in == len_ff) && (matched_adj == distinct_ff);

   always_comb begin
      in_pat_in   = in_pat_ff;
      wp_in       = wp_ff;
      len_in      = len_ff;
      distinct_in = distinct_ff;
      matched_in  = matched_ff;
      found_in    = found_ff;
      res_hit_in  = res_hit_ff;
      res_full_in = res_full_ff;
      if (cmd.clear) begin
         in_pat_in   = '0;
         wp_in       = '0;
         len_in      = '0;
         distinct_in = '0;
         matched_in  = '0;
         found_in    = 1'b0;
         res_hit_in  = 1'b0;
         res_full_in = 1'b0;
      end
      if (cmd.simple) begin
         res_hit_in  = simple_hit;
         res_full_in = simple_full;
         if (simple_hit) found_in = 1'b1;
      end
      if (cmd.pat_upd) begin
         in_pat_in[sym_ff] = 1'b1;
         if (!adj_member) distinct_in = distinct_ff + CNT_W'(1);
         matched_in  = matched_adj;
         len_in      = len_ff + LEN_W'(1);
         res_hit_in  = 1'b0;
         res_full_in = 1'b0;
      end
      if (cmd.old_upd) begin
         matched_in = matched_adj;
      end
      if (cmd.s_upd) begin
         matched_in = matched_adj;
         if (LEN_W'(wp_ff) == len_ff - LEN_W'(1)) begin
            wp_in = '0;
         end else begin
            wp_in = wp_ff + PTR_W'(1);
         end
         res_hit_in  = text_hit;
         res_full_in = 1'b0;
         if (text_hit) found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pat_ff   <= '0;
         wp_ff       <= '0;
         len_ff      <= '0;
         seen_ff     <= '0;
         distinct_ff <= '0;
         matched_ff  <= '0;
         found_ff    <= 1'b0;
      end else begin
         in_pat_ff   <= in_pat_in;
         wp_ff       <= wp_in;
         len_ff      <= len_in;
         seen_ff     <= cmd.clear ? '0 : seen_in;
         distinct_ff <= distinct_in;
         matched_ff  <= matched_in;
         found_ff    <= found_in;
      end
      res_hit_ff  <= res_hit_in;
      res_full_ff <= res_full_in;
   end

   // output register; a pending result survives a clear item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.push) begin
         rsp_bits_ff <= {res_full_ff, found_ff, res_hit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sws_pkg::RSP_DATA_W - sws_pkg::RSP_BITS){1'b0}}, rsp_bits_ff};

   // symbol balance: pattern count minus window count
   assign bal_raddr = cmd.old_rd ? win_rdata : sym_ff;
   assign bal_waddr = adj_addr;
   assign bal_wdata = bal_new;
   assign bal_we    = cmd.pat_upd || ((cmd.old_upd || cmd.s_upd) && adj_member);

   sws_ram #(
      .WIDTH (BAL_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_bal_ram (
      .clock (clock),
      .we    (bal_we),
      .waddr (bal_waddr),
      .wdata (bal_wdata),
      .raddr (bal_raddr),
      .rdata (bal_rdata)
   );

   // ring of recent text bytes; read continuously at the write pointer
   sws_ram #(
      .WIDTH (SYM_W),
      .DEPTH (PATTERN_MAX)
   ) u_win_ram (
      .clock (clock),
      .we    (cmd.s_upd),
      .waddr (wp_ff),
      .wdata (sym_ff),
      .raddr (wp_ff),
      .rdata (win_rdata)
   );

   assign sts.mode     = mode_ff;
   assign sts.pat_ok   = (seen_ff == '0) && len_below_max;
   assign sts.len_zero = (len_ff == '0);
   assign sts.evict    = (seen_ff >= len_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

endmodule

/* verif/sliding_window_anagram_search_top_tb.sv */
`timescale 1ns / 1ps

module sliding_window_anagram_search_top_tb;

   localparam int PATTERN_MAX   = 256;
   localparam int ALPHABET_SIZE = 256;

   // tuser code that the block decodes as no operation
   localparam logic [sws_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   // stop adding random scenarios once this many items have been queued
   localparam int RANDOM_ITEMS = 850;
   // quiet cycles after the last result
   localparam int QUIET_CYCLES = 24;

   // receiver stall styles
   localparam int STALL_NONE  = 0;
   localparam int STALL_COIN  = 1;
   localparam int STALL_HEAVY = 2;
   localparam int STALL_RUNS  = 3;

   typedef struct {
      logic [sws_pkg::MODE_W-1:0]   mode;
      logic [sws_pkg::SYMBOL_W-1:0] symbol;
      bit                           drain;   // hold off until every result is back
   } search_item_type;

   typedef struct packed {
      logic window_match;
      logic match_seen;
      logic pattern_full;
   } search_flags_type;

   // ---------------------------------------------------------------
   // DUT ports
   // ---------------------------------------------------------------
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [sws_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] symbol
   logic [sws_pkg::REQ_USER_W-1:0] req_tuser  = '0;   // [1:0] mode
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [sws_pkg::RSP_DATA_W-1:0] rsp_tdata;         // [0] window_match, [1] match_seen,
                                                      // [2] pattern_full, [7:3] zero

   sliding_window_anagram_search_top #(
      .PATTERN_MAX  (PATTERN_MAX),
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Search predictor: shadow copy of the block's search state
   // ---------------------------------------------------------------
   int                           balance   [ALPHABET_SIZE];  // pattern count - window count
   bit                           member    [ALPHABET_SIZE];  // symbol occurs in the pattern
   logic [sws_pkg::SYMBOL_W-1:0] ring      [PATTERN_MAX];    // last pat_len text bytes
   int                           ring_ptr;
   int                           pat_len;
   int                           n_distinct;
   int                           n_balanced;                 // members with zero balance
   int                           text_count;                 // saturates at pat_len
   bit                           hit_latched;

   function automatic void clear_search();
      foreach (balance[i]) begin
         balance[i] = 0;
         member[i]  = 1'b0;
      end
      foreach (ring[i]) ring[i] = '0;
      ring_ptr    = 0;
      pat_len     = 0;
      n_distinct  = 0;
      n_balanced  = 0;
      text_count  = 0;
      hit_latched = 1'b0;
   endfunction

   // only pattern symbols are tracked; keeps the zero-balance count current
   function automatic void shift_balance(input int sym, input int delta);
      if (!member[sym]) return;
      if (balance[sym] == 0) n_balanced--;
      balance[sym] += delta;
      if (balance[sym] == 0) n_balanced++;
   endfunction

   function automatic search_flags_type predict_search(
      input logic [sws_pkg::MODE_W-1:0]   mode,
      input logic [sws_pkg::SYMBOL_W-1:0] sym);
      search_flags_type r;
      int               wp;
      r  = '0;
      wp = 0;
      case (mode)
         sws_pkg::MODE_CLEAR: begin
            clear_search();
         end
         sws_pkg::MODE_PATTERN: begin
            // pattern is frozen once text has arrived for a non-empty pattern
            if (text_count == 0) begin
               if (pat_len >= PATTERN_MAX) begin
                  r.pattern_full = 1'b1;
               end else begin
                  if (!member[sym]) begin
                     member[sym] = 1'b1;
                     n_distinct++;
                     n_balanced++;
                  end
                  shift_balance(sym, 1);
                  pat_len++;
               end
            end
         end
         sws_pkg::MODE_TEXT: begin
            if (pat_len == 0) begin
               r.window_match = 1'b1;   // empty pattern matches every byte
            end else begin
               wp = ring_ptr % pat_len;
               if (text_count >= pat_len) shift_balance(ring[wp], 1);   // evict
               shift_balance(sym, -1);
               ring[wp] = sym;
               wp++;
               if (wp >= pat_len) wp = 0;
               ring_ptr = wp;
               if (text_count < pat_len) text_count++;
               if (text_count == pat_len && n_balanced == n_distinct)
                  r.window_match = 1'b1;
            end
            if (r.window_match) hit_latched = 1'b1;
         end
         default: begin
         end
      endcase
      r.match_seen = hit_latched;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus store and scoreboard
   // ---------------------------------------------------------------
   search_item_type  pending_items[$];
   search_flags_type expected_flags[$];
   int               items_total    = 0;
   int               items_accepted = 0;
   int               stim_count     = 0;
   int               error_count    = 0;
   bit               req_taken      = 1'b0;   // req transfer at the last rising edge

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   task automatic add_item(input logic [sws_pkg::MODE_W-1:0] mode,
                           input logic [sws_pkg::SYMBOL_W-1:0] sym,
                           input bit drain = 1'b0);
      search_item_type it;
      it.mode   = mode;
      it.symbol = sym;
      it.drain  = drain;
      pending_items.push_back(it);
      if (mode != MODE_UNUSED) stim_count++;
   endtask

   // text bytes forming a shuffled copy of the pattern: the window that
   // ends on the last byte is an anagram
   task automatic emit_permutation(input logic [sws_pkg::SYMBOL_W-1:0] src[$]);
      logic [sws_pkg::SYMBOL_W-1:0] perm[$];
      logic [sws_pkg::SYMBOL_W-1:0] t;
      int                           j;
      perm = src;
      for (int i = perm.size() - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         t       = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      foreach (perm[i]) add_item(sws_pkg::MODE_TEXT, perm[i]);
   endtask

   // ---------------------------------------------------------------
   // Request driver: bursts of random length, random gaps in between.
   // Changes at the falling edge; a held item stays put until transfer.
   // ---------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin : drive_req
      search_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0 &&
                      !(pending_items[0].drain && expected_flags.size() != 0)) begin
            it = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= it.mode;
            req_tdata  <= it.symbol;
            if (burst_left == 0) begin
               // mostly short bursts, now and then a long run; the gap is drawn on its own
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response ready: stall style, redrawn whenever its age counter runs out:
   //   always ready, coin flip, mostly stalled, long runs
   // ---------------------------------------------------------------
   int stall_style = STALL_NONE;
   int style_age   = 0;
   int run_left    = 0;

   always @(negedge clock) begin : drive_rsp_ready
      if (style_age == 0) begin
         stall_style = $urandom_range(STALL_NONE, STALL_RUNS);
         style_age   = 100;
      end
      style_age--;
      case (stall_style)
         STALL_NONE:  rsp_tready <= 1'b1;
         STALL_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (run_left == 0) begin
               run_left = $urandom_range(1, 12);
               rsp_tready <= ~rsp_tready;
            end else begin
               run_left--;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Monitor: samples at the rising edge. Results are checked before the
   // new request is predicted so a stray result is never masked.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch
      search_flags_type want;
      search_flags_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.window_match = rsp_tdata[0];
            got.match_seen   = rsp_tdata[1];
            got.pattern_full = rsp_tdata[2];
            if (expected_flags.size() == 0) begin
               report_mismatch($sformatf("result 0x%02h with nothing outstanding", rsp_tdata));
            end else begin
               want = expected_flags.pop_front();
               if (got.window_match !== want.window_match)
                  report_mismatch($sformatf("window_match %b, want %b",
                                            got.window_match, want.window_match));
               if (got.match_seen !== want.match_seen)
                  report_mismatch($sformatf("match_seen %b, want %b",
                                            got.match_seen, want.match_seen));
               if (got.pattern_full !== want.pattern_full)
                  report_mismatch($sformatf("pattern_full %b, want %b",
                                            got.pattern_full, want.pattern_full));
               if (rsp_tdata[sws_pkg::RSP_DATA_W-1:sws_pkg::RSP_BITS] !== '0)
                  report_mismatch($sformatf("pad bits 0x%02h, want zero", rsp_tdata));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_flags.push_back(predict_search(req_tuser, req_tdata));
            items_accepted++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------
   initial begin : stimulus
      logic [sws_pkg::SYMBOL_W-1:0] pat[$];
      logic [sws_pkg::SYMBOL_W-1:0] sym_set[$];
      int                           plen;
      int                           kind;
      int                           chunks;
      int                           scenario;
      bit                           drain;

      clear_search();

      // --- directed: empty pattern, extremes, unused mode, pattern after text
      add_item(sws_pkg::MODE_TEXT,    8'h00);          // empty pattern hits at once
      add_item(sws_pkg::MODE_TEXT,    8'hFF);
      add_item(MODE_UNUSED,           8'hAA, 1'b1);    // sticky flag still shown
      add_item(sws_pkg::MODE_CLEAR,   8'hFF);          // symbol ignored on clear
      add_item(MODE_UNUSED,           8'h55);
      add_item(sws_pkg::MODE_PATTERN, 8'h00);
      add_item(sws_pkg::MODE_PATTERN, 8'hFF);
      add_item(sws_pkg::MODE_PATTERN, 8'h00);
      add_item(sws_pkg::MODE_TEXT,    8'hFF);          // window filling
      add_item(sws_pkg::MODE_TEXT,    8'h00);
      add_item(sws_pkg::MODE_TEXT,    8'h00);          // {FF,00,00}: anagram
      add_item(sws_pkg::MODE_TEXT,    8'h07);          // non-member enters
      add_item(sws_pkg::MODE_TEXT,    8'h00);
      add_item(sws_pkg::MODE_TEXT,    8'hFF);
      add_item(sws_pkg::MODE_TEXT,    8'h00);          // {00,FF,00}: anagram again
      add_item(sws_pkg::MODE_PATTERN, 8'h55);          // frozen pattern: ignored
      add_item(sws_pkg::MODE_TEXT,    8'h55);
      add_item(sws_pkg::MODE_TEXT,    8'hFF);
      add_item(sws_pkg::MODE_TEXT,    8'h00);
      add_item(sws_pkg::MODE_CLEAR,   8'h00);
      add_item(sws_pkg::MODE_PATTERN, 8'h80);
      add_item(sws_pkg::MODE_TEXT,    8'h80);          // one-byte pattern
      add_item(sws_pkg::MODE_TEXT,    8'h7F);

      // --- random scenarios: usually a clear, then pattern, then text with planted anagrams
      stim_count = 0;
      scenario   = 0;
      while (stim_count < RANDOM_ITEMS) begin
         drain = (scenario == 0) || ($urandom_range(0, 3) == 0);
         if (scenario == 8) begin
            // fill the pattern store, overflow it, then slide over a permutation
            add_item(sws_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)), drain);
            pat.delete();
            for (int i = 0; i < PATTERN_MAX; i++) begin
               case ($urandom_range(0, 3))
                  0:       pat.push_back(8'hFF);
                  1:       pat.push_back(8'($urandom_range(0, 255)));
                  default: pat.push_back(8'h00);
               endcase
               add_item(sws_pkg::MODE_PATTERN, pat[i]);
            end
            add_item(sws_pkg::MODE_PATTERN, 8'($urandom_range(0, 255)));
            add_item(sws_pkg::MODE_PATTERN, 8'($urandom_range(0, 255)));
            emit_permutation(pat);
            for (int i = 0; i < 12; i++)
               add_item(sws_pkg::MODE_TEXT, pat[$urandom_range(0, 255)]);
         end else begin
            kind = $urandom_range(0, 9);
            // without a clear the old state carries on; new pattern bytes
            // are then ignored if text has already been seen
            if (kind != 0) add_item(sws_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)), drain);
            sym_set.delete();
            for (int i = $urandom_range(1, 4); i > 0; i--)
               sym_set.push_back(8'($urandom_range(0, 255)));
            if (kind == 1)      plen = 0;
            else if (kind == 2) plen = $urandom_range(7, 20);
            else                plen = $urandom_range(1, 6);
            pat.delete();
            for (int i = 0; i < plen; i++) begin
               if ($urandom_range(0, 9) == 0) pat.push_back(8'($urandom_range(0, 255)));
               else pat.push_back(sym_set[$urandom_range(0, sym_set.size() - 1)]);
               add_item(sws_pkg::MODE_PATTERN, pat[i], drain && kind == 0 && i == 0);
            end
            chunks = $urandom_range(1, 5);
            for (int c = 0; c < chunks; c++) begin
               case ($urandom_range(0, 5))
                  0, 1, 2: emit_permutation(pat);
                  3: begin
                     for (int i = $urandom_range(1, 8); i > 0; i--)
                        add_item(sws_pkg::MODE_TEXT,
                                 sym_set[$urandom_range(0, sym_set.size() - 1)]);
                  end
                  4: begin
                     for (int i = $urandom_range(1, 4); i > 0; i--)
                        add_item(sws_pkg::MODE_TEXT, 8'($urandom_range(0, 255)));
                  end
                  default: begin
                     // noise: unused mode, stray pattern byte, random mode
                     add_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
                     add_item(sws_pkg::MODE_PATTERN, 8'($urandom_range(0, 255)));
                     if ($urandom_range(0, 3) == 0)
                        add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                  end
               endcase
            end
         end
         scenario++;
      end
      items_total = pending_items.size();

      // reset released at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every item transferred, then every result back
      while (items_accepted != items_total) @(negedge clock);
      while (expected_flags.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
      if (expected_flags.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_flags.size()));

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* sim.f */
src/sws_pkg.sv
src/sws_ram.sv
src/sws_ctrl.sv
src/sws_dp.sv
src/sliding_window_anagram_search_top.sv
verif/sliding_window_anagram_search_top_tb.sv
